/* design/rmsvad_pkg.sv */
// ----------------------------------------------------------------------------
// rmsvad_pkg
// shared types and constants of the rms voice activity detector
// ----------------------------------------------------------------------------
package rmsvad_pkg;

  localparam int PCM_W    = 16;
  localparam int SQR_W    = 31;
  localparam int LVL_W    = 24;
  localparam int HANG_W   = 4;
  localparam int WGT_W    = 16;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W   = LVL_W + 1;
  localparam int PROD_W   = DIFF_W + WGT_W + 1;

  localparam logic [LVL_W-1:0]  LVL_MAX    = {LVL_W{1'b1}};
  localparam logic [HANG_W-1:0] QUIET_MAX  = {HANG_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HANG   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd3;

  localparam logic [LVL_W-1:0]  START_RST  = 24'd150995;
  localparam logic [LVL_W-1:0]  HOLD_RST   = 24'd83886;
  localparam logic [HANG_W-1:0] HANG_RST   = 4'd8;
  localparam logic [WGT_W-1:0]  WEIGHT_RST = 16'd19661;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_SQRT,
    S_MUL,
    S_OUT
  } rmsvad_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
  } rmsvad_ctl_t;

endpackage

/* design/rmsvad_accum.sv */
// ----------------------------------------------------------------------------
// rmsvad_accum
// sum of squares and sample count of the open block
// ----------------------------------------------------------------------------
module rmsvad_accum import rmsvad_pkg::*; #(
  parameter int MAXS  = 4096,
  parameter int CNT_W = 13,
  parameter int SUM_W = 43
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en_i,
  input  logic                    clr_i,
  input  logic signed [PCM_W-1:0] sample_i,
  input  logic                    present_i,
  output logic [SUM_W-1:0]        sum_o,
  output logic [CNT_W-1:0]        cnt_o
);

  logic [SUM_W-1:0]        sum_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [2*PCM_W-1:0] sq;
  logic                    take;

  assign sq   = sample_i * sample_i;
  assign take = en_i && present_i && (cnt_r < CNT_W'(MAXS));

  always_ff @(posedge clk) begin
    if (!rst_n || clr_i) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (take) begin
      sum_r <= sum_r + SUM_W'(sq[SQR_W-1:0]);
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sum_o = sum_r;
  assign cnt_o = cnt_r;

endmodule

/* design/rmsvad_root.sv */
// ----------------------------------------------------------------------------
// rmsvad_root
// shared compare-subtract unit: restoring divide, then digit-by-digit root
// ----------------------------------------------------------------------------
module rmsvad_root import rmsvad_pkg::*; #(
  parameter int SUM_W = 43,
  parameter int CNT_W = 13,
  parameter int LFB   = 8
) (
  input  logic             clk,
  input  rmsvad_ctl_t      ctl_i,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [CNT_W-1:0] cnt_i,
  output logic [LVL_W-1:0] level_o
);

  localparam int NUM_W  = SUM_W + 2 * LFB;
  localparam int ROOT_W = (NUM_W + 1) / 2;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int REM_W  = ((CNT_W > ROOT_W + 1) ? CNT_W : ROOT_W + 1) + 2;
  localparam int EXT_W  = (ROOT_W > LVL_W) ? ROOT_W : LVL_W;

  logic [SQ_W-1:0]   work_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  operand;
  logic [REM_W:0]    diff;
  logic              ge;
  logic [EXT_W-1:0]  root_ext;

  always_comb begin
    if (ctl_i.sqrt_step) begin
      shifted = {rem_r[REM_W-3:0], work_r[SQ_W-1 -: 2]};
      operand = REM_W'({root_r, 2'b01});
    end else begin
      shifted = {rem_r[REM_W-2:0], work_r[SQ_W-1]};
      operand = REM_W'(cnt_r);
    end
    diff = {1'b0, shifted} - {1'b0, operand};
    ge   = !diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      work_r <= SQ_W'(sum_i) << (2 * LFB);
      cnt_r  <= cnt_i;
      rem_r  <= '0;
    end else begin
      if (ctl_i.div_step) begin
        work_r <= {work_r[SQ_W-2:0], ge};
        rem_r  <= ctl_i.sqrt_init ? '0 : (ge ? diff[REM_W-1:0] : shifted);
      end
      if (ctl_i.sqrt_step) begin
        work_r <= {work_r[SQ_W-3:0], 2'b00};
        rem_r  <= ge ? diff[REM_W-1:0] : shifted;
        root_r <= {root_r[ROOT_W-2:0], ge};
      end
      if (ctl_i.sqrt_init) begin
        root_r <= '0;
      end
    end
  end

  // saturate to the level width
  assign root_ext = EXT_W'(root_r);
  assign level_o  = (root_ext > EXT_W'(LVL_MAX)) ? LVL_MAX : root_ext[LVL_W-1:0];

endmodule

/* design/block_rms_voice_activity_detector.sv */
// ----------------------------------------------------------------------------
// block_rms_voice_activity_detector
// block rms level, smoothed level and speaking flag with hysteresis
// ----------------------------------------------------------------------------
// A sample item is taken whenever it is offered while the detector is idle.
// The item that closes a block holds the input stalled while one shared
// compare-subtract unit first divides the scaled sum of squares by the
// sample count, one quotient bit per cycle, and then takes its square root,
// one root bit per cycle. The quotient is SQ_W bits wide, the numerator width
// (sum width plus twice LEVEL_FRAC_BITS, rounded up to even), and the root
// ROOT_W bits, half of it. An empty block skips the unit. One result follows
// each closing item, after a single multiply-add for the smoothed level; the
// result sits in an output register so the next block can start while it
// waits, and a second result waits in the last step until the first one is
// taken.
// ----------------------------------------------------------------------------
module block_rms_voice_activity_detector import rmsvad_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = 4096,
  parameter int LEVEL_FRAC_BITS   = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PCM_W-1:0] in_pcm_sample,
  input  logic                    in_sample_present,
  input  logic                    in_block_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LVL_W-1:0]        out_block_rms,
  output logic [LVL_W-1:0]        out_smoothed_level,
  output logic                    out_speaking,
  output logic                    out_speaking_changed,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int SUM_W  = CNT_W + SQR_W - 1;
  localparam int NUM_W  = SUM_W + 2 * LEVEL_FRAC_BITS;
  localparam int ROOT_W = (NUM_W + 1) / 2;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int IT_W   = $clog2(SQ_W + 1);

  rmsvad_state_t state_r, state_nxt;
  rmsvad_ctl_t   ctl;

  logic [LVL_W-1:0]  start_r;
  logic [LVL_W-1:0]  hold_r;
  logic [HANG_W-1:0] hang_r;
  logic [WGT_W-1:0]  weight_r;

  logic [LVL_W-1:0]  avg_r, avg_nxt;
  logic              spk_r, spk_nxt;
  logic [HANG_W-1:0] quiet_r, quiet_nxt, quiet_inc;

  logic [IT_W-1:0]   it_r;
  logic              empty_r;
  logic [LVL_W-1:0]  level_r;
  logic signed [PROD_W-1:0] prod_r;

  logic              out_valid_r;
  logic [LVL_W-1:0]  out_rms_r;
  logic [LVL_W-1:0]  out_avg_r;
  logic              out_spk_r;
  logic              out_chg_r;

  logic              in_xfer;
  logic              acc_clr;
  logic              out_free;
  logic              out_load;
  logic              div_last;
  logic              sqrt_last;
  logic [SUM_W-1:0]  acc_sum;
  logic [CNT_W-1:0]  acc_cnt;
  logic [LVL_W-1:0]  root_level;
  logic [LVL_W-1:0]  level_sel;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] avg_sum;

  rmsvad_accum #(
    .MAXS  (MAX_BLOCK_SAMPLES),
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en_i      (in_xfer),
    .clr_i     (acc_clr),
    .sample_i  (in_pcm_sample),
    .present_i (in_sample_present),
    .sum_o     (acc_sum),
    .cnt_o     (acc_cnt)
  );

  rmsvad_root #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W),
    .LFB   (LEVEL_FRAC_BITS)
  ) u_root (
    .clk     (clk),
    .ctl_i   (ctl),
    .sum_i   (acc_sum),
    .cnt_i   (acc_cnt),
    .level_o (root_level)
  );

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_OUT) && out_free;
  assign div_last  = (it_r == IT_W'(SQ_W - 1));
  assign sqrt_last = (it_r == IT_W'(ROOT_W - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer && in_block_end) state_nxt = S_LOAD;
      S_LOAD: state_nxt = (acc_cnt == '0) ? S_MUL : S_DIV;
      S_DIV:  if (div_last) state_nxt = S_SQRT;
      S_SQRT: if (sqrt_last) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = (state_r != S_IDLE);
    acc_clr       = (state_r == S_LOAD);
    ctl.load      = (state_r == S_LOAD);
    ctl.div_step  = (state_r == S_DIV);
    ctl.sqrt_init = (state_r == S_DIV) && div_last;
    ctl.sqrt_step = (state_r == S_SQRT);
  end

  // smoothing and hysteresis
  always_comb begin
    level_sel = empty_r ? '0 : root_level;
    diff      = $signed({1'b0, level_sel}) - $signed({1'b0, avg_r});
    avg_sum   = $signed({1'b0, avg_r}) + $signed(prod_r[PROD_W-2:WGT_W]);
    avg_nxt   = avg_sum[LVL_W-1:0];
    quiet_inc = (quiet_r == QUIET_MAX) ? quiet_r : quiet_r + 1'b1;
    spk_nxt   = spk_r;
    quiet_nxt = quiet_r;
    if (spk_r) begin
      if (avg_nxt < hold_r) begin
        quiet_nxt = quiet_inc;
        if (quiet_inc >= hang_r) spk_nxt = 1'b0;
      end else begin
        quiet_nxt = '0;
      end
    end else if (avg_nxt > start_r) begin
      quiet_nxt = '0;
      spk_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      avg_r       <= '0;
      spk_r       <= 1'b0;
      quiet_r     <= '0;
      start_r     <= START_RST;
      hold_r      <= HOLD_RST;
      hang_r      <= HANG_RST;
      weight_r    <= WEIGHT_RST;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
        avg_r       <= avg_nxt;
        spk_r       <= spk_nxt;
        quiet_r     <= quiet_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START:  start_r  <= cfg_wdata[LVL_W-1:0];
          CFG_HOLD:   hold_r   <= cfg_wdata[LVL_W-1:0];
          CFG_HANG:   hang_r   <= cfg_wdata[HANG_W-1:0];
          CFG_WEIGHT: weight_r <= cfg_wdata[WGT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        it_r    <= '0;
        empty_r <= (acc_cnt == '0);
      end
      S_DIV:  it_r <= div_last ? '0 : it_r + 1'b1;
      S_SQRT: it_r <= it_r + 1'b1;
      S_MUL: begin
        level_r <= level_sel;
        prod_r  <= diff * $signed({1'b0, weight_r});
      end
      default: ;
    endcase
    if (out_load) begin
      out_rms_r <= level_r;
      out_avg_r <= avg_nxt;
      out_spk_r <= spk_nxt;
      out_chg_r <= (spk_nxt != spk_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_block_rms        = out_rms_r;
  assign out_smoothed_level   = out_avg_r;
  assign out_speaking         = out_spk_r;
  assign out_speaking_changed = out_chg_r;

  // closing transfer always starts the evaluation
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_block_end |=> in_stall)
    else $error("closing transfer did not start evaluation");

  // change flag agrees with the flag update
  a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_speaking_changed == (spk_r != $past(spk_r)))
    else $error("change flag does not match speaking update");

  // root iterations stay within the root width
  a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> it_r < IT_W'(ROOT_W))
    else $error("root iteration count out of range");

endmodule

/* test/tb_block_rms_voice_activity_detector.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_rms_voice_activity_detector
// self-checking bench for the block rms voice activity detector
// ----------------------------------------------------------------------------
// A short table of directed items, two with expected results, covers empty
// blocks, full-scale samples and a sample on the closing item; an over-long
// block comes next. Random blocks follow: runs of silent, quiet, medium and
// loud blocks under several register settings and idling patterns, one long
// receiver hold-off included. The rest are checked by a bit-accurate predictor.
// ----------------------------------------------------------------------------
module tb_block_rms_voice_activity_detector;
  import rmsvad_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int MAX_SAMPLES = 4096;
  localparam int DIR_N = 20;
  localparam int PHASE_N = 8;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [LVL_W-1:0] rms;
    logic [LVL_W-1:0] smooth;
    logic             spk;
    logic             chg;
  } level_result_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic                    pres;
    logic                    bend;
    logic                    chk;
    level_result_t           want;
  } dir_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] start_thr;
    logic [CFG_W-1:0] hold_thr;
    logic [CFG_W-1:0] hang;
    logic [CFG_W-1:0] weight;
    logic [7:0]       send_pct;
    logic [7:0]       recv_pct;
  } phase_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [PCM_W-1:0] in_pcm_sample;
  logic                    in_sample_present;
  logic                    in_block_end;
  logic                    out_valid;
  logic                    out_stall;
  logic [LVL_W-1:0]        out_block_rms;
  logic [LVL_W-1:0]        out_smoothed_level;
  logic                    out_speaking;
  logic                    out_speaking_changed;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;

  // predictor state
  logic [63:0]       sq_sum;
  int unsigned       smp_cnt;
  logic [LVL_W-1:0]  lvl_avg;
  logic              talk_flag;
  logic [HANG_W-1:0] quiet_cnt;
  logic [LVL_W-1:0]  start_thr;
  logic [LVL_W-1:0]  hold_thr;
  logic [HANG_W-1:0] hang_cnt;
  logic [WGT_W-1:0]  weight;

  level_result_t pending_levels [$];
  int unsigned   mismatch_count;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  logic          hold_req;
  int unsigned   loud_mode;
  int unsigned   mode_left;

  dir_row_t dir_rows [DIR_N];
  phase_t   phases [PHASE_N];

  block_rms_voice_activity_detector DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pcm_sample       (in_pcm_sample),
    .in_sample_present   (in_sample_present),
    .in_block_end        (in_block_end),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_block_rms       (out_block_rms),
    .out_smoothed_level  (out_smoothed_level),
    .out_speaking        (out_speaking),
    .out_speaking_changed(out_speaking_changed),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    logic [63:0] rem;
    root = '0;
    bitv = 64'h1 << 62;
    rem = v;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic track_item(input logic signed [PCM_W-1:0] pcm, input logic pres,
                            input logic bend, output logic closed,
                            output level_result_t res);
    int          sv;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] mean;
    logic [63:0] acc;
    logic [LVL_W-1:0] lvl;
    logic        was;
    closed = 1'b0;
    res = '0;
    if (pres && smp_cnt < MAX_SAMPLES) begin
      sv = pcm;
      mag = 64'(sv < 0 ? -sv : sv);
      sq_sum = sq_sum + mag * mag;
      smp_cnt++;
    end
    if (bend) begin
      if (smp_cnt == 0) begin
        lvl = '0;
      end else begin
        q = sq_sum / 64'(smp_cnt);
        r = sq_sum % 64'(smp_cnt);
        mean = (q << 16) + ((r << 16) / 64'(smp_cnt));
        q = isqrt64(mean);
        lvl = (q > 64'(LVL_MAX)) ? LVL_MAX : q[LVL_W-1:0];
      end
      sq_sum = '0;
      smp_cnt = 0;
      acc = 64'(lvl_avg) * (64'd65536 - 64'(weight)) + 64'(lvl) * 64'(weight);
      lvl_avg = acc[16 +: LVL_W];
      was = talk_flag;
      if (talk_flag) begin
        if (lvl_avg < hold_thr) begin
          if (quiet_cnt != QUIET_MAX) quiet_cnt++;
          if (quiet_cnt >= hang_cnt) talk_flag = 1'b0;
        end else begin
          quiet_cnt = '0;
        end
      end else if (lvl_avg > start_thr) begin
        quiet_cnt = '0;
        talk_flag = 1'b1;
      end
      res.rms = lvl;
      res.smooth = lvl_avg;
      res.spk = talk_flag;
      res.chg = (talk_flag != was);
      closed = 1'b1;
    end
  endtask

  // entered and left at a falling edge
  task automatic offer_item(input logic signed [PCM_W-1:0] pcm, input logic pres,
                            input logic bend, input logic chk, input level_result_t typed);
    logic          closed;
    level_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_pcm_sample = pcm;
    in_sample_present = pres;
    in_block_end = bend;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    track_item(pcm, pres, bend, closed, res);
    if (closed) pending_levels.push_back(chk ? typed : res);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CFG_START:  start_thr = val[LVL_W-1:0];
      CFG_HOLD:   hold_thr = val[LVL_W-1:0];
      CFG_HANG:   hang_cnt = val[HANG_W-1:0];
      CFG_WEIGHT: weight = val[WGT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_random_block(inout int unsigned sent);
    int unsigned             len;
    int unsigned             amp;
    int unsigned             pick;
    logic                    last_has_sample;
    logic signed [PCM_W-1:0] s;
    if (mode_left == 0) begin
      loud_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(2, 20);
    end
    mode_left--;
    pick = $urandom_range(0, 99);
    if (pick < 8) len = 0;
    else if (pick < 75) len = $urandom_range(1, 12);
    else if (pick < 95) len = $urandom_range(13, 64);
    else len = $urandom_range(65, 300);
    case (loud_mode)
      0: amp = 0;
      1: amp = 300;
      2: amp = 3000;
      default: amp = 32768;
    endcase
    last_has_sample = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) offer_item(PCM_W'($urandom), 1'b0, 1'b0, 1'b0, '0);
      if (amp >= 32768) begin
        s = PCM_W'($urandom);
      end else begin
        s = PCM_W'($urandom_range(0, amp));
        if ($urandom_range(0, 1) == 1) s = -s;
      end
      offer_item(s, 1'b1, (i == len - 1) && last_has_sample, 1'b0, '0);
    end
    if (!last_has_sample) offer_item(PCM_W'($urandom), 1'b0, 1'b1, 1'b0, '0);
    sent += len + (last_has_sample ? 0 : 1);
  endtask

  // receiver: random stall, or a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    level_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_levels.size() == 0) begin
        $error("unexpected result transfer: rms %0d smoothed %0d", out_block_rms,
               out_smoothed_level);
        mismatch_count++;
      end else begin
        want = pending_levels.pop_front();
        if (out_block_rms !== want.rms) begin
          $error("block_rms: expected %0d, got %0d", want.rms, out_block_rms);
          mismatch_count++;
        end
        if (out_smoothed_level !== want.smooth) begin
          $error("smoothed_level: expected %0d, got %0d", want.smooth, out_smoothed_level);
          mismatch_count++;
        end
        if (out_speaking !== want.spk) begin
          $error("speaking: expected %0d, got %0d", want.spk, out_speaking);
          mismatch_count++;
        end
        if (out_speaking_changed !== want.chg) begin
          $error("speaking_changed: expected %0d, got %0d", want.chg, out_speaking_changed);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_block_rms_voice_activity_detector: FAIL");
    $finish;
  end

  initial begin
    int unsigned sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pcm_sample = '0;
    in_sample_present = 1'b0;
    in_block_end = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_START;
    cfg_wdata = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    loud_mode = 0;
    mode_left = 0;
    sq_sum = '0;
    smp_cnt = 0;
    lvl_avg = '0;
    talk_flag = 1'b0;
    quiet_cnt = '0;
    start_thr = START_RST;
    hold_thr = HOLD_RST;
    hang_cnt = HANG_RST;
    weight = WEIGHT_RST;

    dir_rows = '{
      '{16'sd0,      1'b0, 1'b1, 1'b1, '{24'd0, 24'd0, 1'b0, 1'b0}},
      '{-16'sd32768, 1'b1, 1'b1, 1'b1, '{24'd8388608, 24'd2516608, 1'b1, 1'b1}},
      '{16'sd32767,  1'b0, 1'b0, 1'b0, '0},
      '{16'sd32767,  1'b1, 1'b0, 1'b0, '0},
      '{-16'sd32767, 1'b1, 1'b1, 1'b0, '0},
      '{16'sd0,      1'b0, 1'b1, 1'b0, '0},
      '{16'sd0,      1'b1, 1'b1, 1'b0, '0},
      '{16'sd1,      1'b1, 1'b0, 1'b0, '0},
      '{-16'sd1,     1'b1, 1'b0, 1'b0, '0},
      '{16'sd2,      1'b1, 1'b1, 1'b0, '0},
      '{16'sh5555,   1'b1, 1'b0, 1'b0, '0},
      '{16'shAAAA,   1'b1, 1'b1, 1'b0, '0},
      '{16'shFFFF,   1'b0, 1'b1, 1'b0, '0},
      '{16'sd0,      1'b0, 1'b1, 1'b0, '0},
      '{16'sd0,      1'b0, 1'b1, 1'b0, '0},
      '{16'sd0,      1'b0, 1'b1, 1'b0, '0},
      '{16'sd0,      1'b0, 1'b1, 1'b0, '0},
      '{16'sd0,      1'b0, 1'b1, 1'b0, '0},
      '{16'sd100,    1'b1, 1'b1, 1'b0, '0},
      '{16'sd0,      1'b0, 1'b1, 1'b0, '0}
    };

    phases = '{
      '{24'd150995,  24'd83886,   24'd8,  24'd19661,   8'd0,  8'd0},
      '{24'd150995,  24'd83886,   24'd8,  24'd19661,   8'd78, 8'd0},
      '{24'd0,       24'd0,       24'd1,  24'd65535,   8'd0,  8'd78},
      '{24'd40000,   24'd30000,   24'd0,  24'hFF8000,  8'd13, 8'd13},
      '{24'd8388608, 24'd8388608, 24'd15, 24'd0,       8'd78, 8'd0},
      '{24'hFFFFFF,  24'hFFFFFF,  24'd3,  24'd1,       8'd0,  8'd78},
      '{24'd100000,  24'd90000,   24'd15, 24'd50000,   8'd13, 8'd13},
      '{24'd60000,   24'd150000,  24'd2,  24'd30000,   8'd0,  8'd0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      offer_item(dir_rows[i].pcm, dir_rows[i].pres, dir_rows[i].bend, dir_rows[i].chk,
                 dir_rows[i].want);

    // over-long block: samples past the limit must not count
    for (int i = 0; i < MAX_SAMPLES; i++)
      offer_item((i % 2 == 0) ? 16'sd1000 : -16'sd1000, 1'b1, 1'b0, 1'b0, '0);
    for (int i = 0; i < 20; i++) offer_item(16'sd32767, 1'b1, 1'b0, 1'b0, '0);
    offer_item(-16'sd32768, 1'b1, 1'b1, 1'b0, '0);

    for (int p = 0; p < PHASE_N; p++) begin
      drain_results();
      write_reg(CFG_START, phases[p].start_thr);
      write_reg(CFG_HOLD, phases[p].hold_thr);
      write_reg(CFG_HANG, phases[p].hang);
      write_reg(CFG_WEIGHT, phases[p].weight);
      send_idle_pct = phases[p].send_pct;
      recv_stall_pct = phases[p].recv_pct;
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_block(sent);
    end

    in_valid = 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_levels.size() == 0) begin
      $display("tb_block_rms_voice_activity_detector: PASS");
    end else begin
      $display("tb_block_rms_voice_activity_detector: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/rmsvad_pkg.sv
design/rmsvad_accum.sv
design/rmsvad_root.sv
design/block_rms_voice_activity_detector.sv
test/tb_block_rms_voice_activity_detector.sv
